// File: src/assert_macros.svh
// Assertion macros for the timer RTL, included by the top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/pwmt_pkg.sv
// Types and constants shared by the timer front end, request queue and core.
package pwmt_pkg;

  localparam int unsigned CountWidthDefault = 16;
  localparam int unsigned DataW = 16;
  localparam int unsigned AddrW = 4;

  // Request queue between front end and core
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW = $clog2(QueueDepth);
  localparam int unsigned QueueCntW = QueuePtrW + 1;

  // Operation codes on the input channel
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // Register map
  localparam logic [AddrW-1:0] ADDR_CTRL  = 4'd0;
  localparam logic [AddrW-1:0] ADDR_STAT  = 4'd1;
  localparam logic [AddrW-1:0] ADDR_EVENT = 4'd2;
  localparam logic [AddrW-1:0] ADDR_CMODE = 4'd3;
  localparam logic [AddrW-1:0] ADDR_CHEN  = 4'd4;
  localparam logic [AddrW-1:0] ADDR_COUNT = 4'd5;
  localparam logic [AddrW-1:0] ADDR_PSC   = 4'd6;
  localparam logic [AddrW-1:0] ADDR_ARR   = 4'd7;
  localparam logic [AddrW-1:0] ADDR_CCR   = 4'd8;
  localparam logic [AddrW-1:0] ADDR_BRK   = 4'd9;

  // Register bit positions
  localparam int unsigned CtrlArpeBit = 7;
  localparam int unsigned CmodeLsb    = 4;
  localparam int unsigned CmodeOcpeBit = 3;
  localparam int unsigned BrkMoeBit   = 15;

  // Output compare modes
  localparam logic [2:0] MODE_FORCE_LOW  = 3'b100;
  localparam logic [2:0] MODE_FORCE_HIGH = 3'b101;
  localparam logic [2:0] MODE_PWM1       = 3'b110;
  localparam logic [2:0] MODE_PWM2       = 3'b111;

  typedef enum logic [1:0] {
    KIND_NOP,
    KIND_TICK,
    KIND_WRITE,
    KIND_READ
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [AddrW-1:0]  addr;
    logic [DataW-1:0]  data;
  } req_t;

  typedef struct packed {
    logic                 full;
    logic                 empty;
    logic [QueueCntW-1:0] count;
  } q_stat_t;

endpackage

// File: src/pwmt_front.sv
// Front end: accepts input requests and classifies them for the core.
module pwmt_front import pwmt_pkg::*; (
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [1:0]       operation_i,
  input  logic [AddrW-1:0] reg_select_i,
  input  logic [DataW-1:0] write_data_i,
  input  q_stat_t          q_stat_i,
  output logic             push_o,
  output req_t             req_o
);

  logic addr_known;

  assign addr_known = (reg_select_i <= ADDR_BRK);

  assign in_ready_o = !q_stat_i.full;
  assign push_o     = in_valid_i && !q_stat_i.full;

  always_comb begin
    req_o.addr = reg_select_i;
    req_o.data = write_data_i;
    req_o.kind = KIND_NOP;
    unique case (operation_i)
      OP_TICK:  req_o.kind = KIND_TICK;
      // unknown registers and the event register read as zero: drop to no-op
      OP_WRITE: req_o.kind = addr_known ? KIND_WRITE : KIND_NOP;
      OP_READ:  req_o.kind = (addr_known && reg_select_i != ADDR_EVENT) ? KIND_READ : KIND_NOP;
      default:  req_o.kind = KIND_NOP;
    endcase
  end

endmodule

// File: src/pwmt_queue.sv
// Short request queue between front end and core.
module pwmt_queue import pwmt_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  req_t    req_i,
  input  logic    pop_i,
  output req_t    req_o,
  output q_stat_t stat_o
);

  req_t                 slot_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QueueCntW-1:0] cnt_q, cnt_d;
  logic                 do_push, do_pop;

  assign stat_o.full  = (cnt_q == QueueCntW'(QueueDepth));
  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.count = cnt_q;

  assign do_push = push_i && !stat_o.full;
  assign do_pop  = pop_i && !stat_o.empty;

  assign req_o = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q + QueueCntW'(do_push) - QueueCntW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= req_i;
    end
  end

endmodule

// File: src/pwmt_core.sv
// Timer core: executes requests, holds timer state and the result register.
module pwmt_core import pwmt_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = CountWidthDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  req_t             req_i,
  input  logic             q_empty_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [DataW-1:0] read_data_o,
  output logic             pwm_out_o,
  output logic             update_flag_o
);

  localparam int unsigned CW = COUNT_WIDTH;

  logic             cen_q, cen_d;
  logic             arpe_q, arpe_d;
  logic             uif_q, uif_d;
  logic [2:0]       mode_q, mode_d;
  logic             ocpe_q, ocpe_d;
  logic             chen_q, chen_d;
  logic             moe_q, moe_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [DataW-1:0] psc_cnt_q, psc_cnt_d;
  logic [DataW-1:0] psc_wr_q, psc_wr_d;
  logic [DataW-1:0] psc_act_q, psc_act_d;
  logic [CW-1:0]    arr_wr_q, arr_wr_d;
  logic [CW-1:0]    arr_act_q, arr_act_d;
  logic [CW-1:0]    ccr_wr_q, ccr_wr_d;
  logic [CW-1:0]    ccr_act_q, ccr_act_d;
  logic             out_valid_q, out_valid_d;
  logic [DataW-1:0] rdata_q, rdata_d;

  logic             update;
  logic [CW-1:0]    wdata_cnt;
  logic [DataW-1:0] rd_mux;
  logic             below;
  logic             level;

  // Take a new request whenever the result slot is free or being drained.
  assign pop_o     = !q_empty_i && (!out_valid_q || out_ready_i);
  assign wdata_cnt = CW'(req_i.data);

  always_comb begin
    rd_mux = '0;
    unique case (req_i.addr)
      ADDR_CTRL:  begin
        rd_mux[0]           = cen_q;
        rd_mux[CtrlArpeBit] = arpe_q;
      end
      ADDR_STAT:  rd_mux[0] = uif_q;
      ADDR_CMODE: begin
        rd_mux[CmodeLsb +: 3] = mode_q;
        rd_mux[CmodeOcpeBit]  = ocpe_q;
      end
      ADDR_CHEN:  rd_mux[0] = chen_q;
      ADDR_COUNT: rd_mux = DataW'(cnt_q);
      ADDR_PSC:   rd_mux = psc_wr_q;
      ADDR_ARR:   rd_mux = DataW'(arr_wr_q);
      ADDR_CCR:   rd_mux = DataW'(ccr_wr_q);
      ADDR_BRK:   rd_mux[BrkMoeBit] = moe_q;
      default:    rd_mux = '0;
    endcase
  end

  always_comb begin
    cen_d     = cen_q;
    arpe_d    = arpe_q;
    uif_d     = uif_q;
    mode_d    = mode_q;
    ocpe_d    = ocpe_q;
    chen_d    = chen_q;
    moe_d     = moe_q;
    cnt_d     = cnt_q;
    psc_cnt_d = psc_cnt_q;
    psc_wr_d  = psc_wr_q;
    psc_act_d = psc_act_q;
    arr_wr_d  = arr_wr_q;
    arr_act_d = arr_act_q;
    ccr_wr_d  = ccr_wr_q;
    ccr_act_d = ccr_act_q;
    rdata_d   = rdata_q;
    update    = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;

    if (pop_o) begin
      out_valid_d = 1'b1;
      rdata_d     = '0;
      unique case (req_i.kind)
        KIND_TICK: begin
          if (cen_q) begin
            if (psc_cnt_q >= psc_act_q) begin
              psc_cnt_d = '0;
              if (cnt_q == arr_act_q) begin
                update = 1'b1;
              end else begin
                cnt_d = cnt_q + 1'b1;
              end
            end else begin
              psc_cnt_d = psc_cnt_q + 1'b1;
            end
          end
        end
        KIND_WRITE: begin
          unique case (req_i.addr)
            ADDR_CTRL: begin
              cen_d  = req_i.data[0];
              arpe_d = req_i.data[CtrlArpeBit];
            end
            // status bits clear on zero, hold on one
            ADDR_STAT:  uif_d = uif_q & req_i.data[0];
            ADDR_EVENT: begin
              if (req_i.data[0]) begin
                update    = 1'b1;
                psc_cnt_d = '0;
              end
            end
            ADDR_CMODE: begin
              mode_d = req_i.data[CmodeLsb +: 3];
              ocpe_d = req_i.data[CmodeOcpeBit];
            end
            ADDR_CHEN:  chen_d = req_i.data[0];
            ADDR_COUNT: cnt_d = wdata_cnt;
            ADDR_PSC:   psc_wr_d = req_i.data;
            ADDR_ARR: begin
              arr_wr_d = wdata_cnt;
              if (!arpe_q) begin
                arr_act_d = wdata_cnt;
              end
            end
            ADDR_CCR: begin
              ccr_wr_d = wdata_cnt;
              if (!ocpe_q) begin
                ccr_act_d = wdata_cnt;
              end
            end
            ADDR_BRK:   moe_d = req_i.data[BrkMoeBit];
            default: ;
          endcase
        end
        KIND_READ: rdata_d = rd_mux;
        KIND_NOP:  ;
        default:   ;
      endcase

      // Update event: restart the count, set the update flag and load the shadow values.
      if (update) begin
        cnt_d     = '0;
        uif_d     = 1'b1;
        psc_act_d = psc_wr_q;
        arr_act_d = arr_wr_q;
        ccr_act_d = ccr_wr_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cen_q       <= 1'b0;
      arpe_q      <= 1'b0;
      uif_q       <= 1'b0;
      mode_q      <= '0;
      ocpe_q      <= 1'b0;
      chen_q      <= 1'b0;
      moe_q       <= 1'b0;
      cnt_q       <= '0;
      psc_cnt_q   <= '0;
      psc_wr_q    <= '0;
      psc_act_q   <= '0;
      arr_wr_q    <= '1;
      arr_act_q   <= '1;
      ccr_wr_q    <= '0;
      ccr_act_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cen_q       <= cen_d;
      arpe_q      <= arpe_d;
      uif_q       <= uif_d;
      mode_q      <= mode_d;
      ocpe_q      <= ocpe_d;
      chen_q      <= chen_d;
      moe_q       <= moe_d;
      cnt_q       <= cnt_d;
      psc_cnt_q   <= psc_cnt_d;
      psc_wr_q    <= psc_wr_d;
      psc_act_q   <= psc_act_d;
      arr_wr_q    <= arr_wr_d;
      arr_act_q   <= arr_act_d;
      ccr_wr_q    <= ccr_wr_d;
      ccr_act_q   <= ccr_act_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= rdata_d;
  end

  // State only moves when a result is loaded, so the level follows the held result.
  assign below = (cnt_q < ccr_act_q);

  always_comb begin
    unique case (mode_q)
      MODE_PWM1:       level = below;
      MODE_PWM2:       level = !below;
      MODE_FORCE_HIGH: level = 1'b1;
      default:         level = 1'b0;
    endcase
  end

  assign out_valid_o   = out_valid_q;
  assign read_data_o   = rdata_q;
  assign pwm_out_o     = level & chen_q & moe_q;
  assign update_flag_o = uif_q;

endmodule

// File: src/pwm_timer_with_prescaler_top.sv
// Timer with prescaler and one PWM channel: top level.
//
//   channel | direction | handshake             | payload
//   in      | request   | in_valid_i/in_ready_o | operation_i, reg_select_i, write_data_i
//   out     | result    | out_valid_o/out_ready_i | read_data_o, pwm_out_o, update_flag_o
//
// One request per cycle sustained while out_ready_i is high; an accepted request is
// written into the queue and then executed into the core's result register.
// The two-entry queue keeps the input open while a result waits on out_ready_i, until both entries fill.
// Reset puts the timer in its documented reset state; no clearing pass is needed.
module pwm_timer_with_prescaler_top import pwmt_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = CountWidthDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [1:0]       operation_i,
  input  logic [AddrW-1:0] reg_select_i,
  input  logic [DataW-1:0] write_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [DataW-1:0] read_data_o,
  output logic             pwm_out_o,
  output logic             update_flag_o
);

`include "assert_macros.svh"

  q_stat_t q_stat;
  logic    push;
  logic    pop;
  req_t    front_req;
  req_t    head_req;

  pwmt_front u_front (
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .operation_i  (operation_i),
    .reg_select_i (reg_select_i),
    .write_data_i (write_data_i),
    .q_stat_i     (q_stat),
    .push_o       (push),
    .req_o        (front_req)
  );

  pwmt_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .req_i  (front_req),
    .pop_i  (pop),
    .req_o  (head_req),
    .stat_o (q_stat)
  );

  pwmt_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (head_req),
    .q_empty_i     (q_stat.empty),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .read_data_o   (read_data_o),
    .pwm_out_o     (pwm_out_o),
    .update_flag_o (update_flag_o)
  );

  `ASSERT_IMPL(a_ready_only_when_full, !in_ready_o, q_stat.full, "input stalled with queue space")
  `ASSERT_NEXT(a_queue_fill, push && !pop, q_stat.count == $past(q_stat.count) + 1'b1, "push lost")
  `ASSERT_NEXT(a_out_drain, out_valid_o && out_ready_i && !pop, !out_valid_o, "result repeated")
  `ASSERT_IMPL(a_flag_from_request, $rose(update_flag_o), $past(pop), "update flag set without a request")

endmodule
